@@ rtl/triangular_matrix_vector_multiply_macros.svh @@
// Assertion helpers for the RTL file that checks itself.
`ifndef TRIANGULAR_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define TRIANGULAR_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TMV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmv_pkg.sv @@
`default_nettype none

package tmv_pkg;

  localparam int unsigned MAX_ORDER_DEF = 32;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned ORD_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [63:0] QNAN_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_MAT_WR = 2'd0,
    REQ_VEC_WR = 2'd1,
    REQ_RUN    = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER     = 2'd0,
    CFG_TRANSPOSE = 2'd1,
    CFG_UNIT      = 2'd2,
    CFG_ORDER     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MS,
    ST_MW,
    ST_AS,
    ST_AW,
    ST_NX,
    ST_WB,
    ST_ER,
    ST_EO
  } tmv_state_e;

  // Operand pair handed to a floating-point unit.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } fp_op_t;

endpackage

`default_nettype wire

@@ rtl/tmv_ram.sv @@
`default_nettype none

module tmv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/tmv_fmul.sv @@
`default_nettype none

module tmv_fmul import tmv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire fp_op_t      op_i,
  output logic             done_o,
  output logic [63:0]      result_o
);

  // operand decode
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, is_spec;
  logic [10:0] ea, eb;
  logic [63:0] spec_res;

  assign sa     = op_i.a[63];
  assign sb     = op_i.b[63];
  assign ea     = op_i.a[62:52];
  assign eb     = op_i.b[62:52];
  assign a_nan  = (&ea) && (|op_i.a[51:0]);
  assign b_nan  = (&eb) && (|op_i.b[51:0]);
  assign a_inf  = (&ea) && !(|op_i.a[51:0]);
  assign b_inf  = (&eb) && !(|op_i.b[51:0]);
  assign a_zero = !(|op_i.a[62:0]);
  assign b_zero = !(|op_i.b[62:0]);

  always_comb begin
    is_spec  = 1'b1;
    spec_res = '0;
    priority if (a_nan) begin
      spec_res = op_i.a | QNAN_BIT;
    end else if (b_nan) begin
      spec_res = op_i.b | QNAN_BIT;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_res = DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spec_res = {sa ^ sb, 11'h7FF, 52'b0};
    end else if (a_zero || b_zero) begin
      spec_res = {sa ^ sb, 63'b0};
    end else begin
      is_spec = 1'b0;
    end
  end

  logic [52:0]  ma_q, mb_q;
  logic [10:0]  ea_q, eb_q;
  logic         sign_q;
  logic [1:0]   cnt_q;
  logic         mact_q, ppv_q, ppl_q;
  logic [53:0]  pp_q;
  logic [1:0]   ppsh_q;
  logic [105:0] acc_q;
  logic         v1_q, v2_q, v3_q, done_q;
  logic [13:0]  sh2_q;
  logic [10:0]  ef2_q, ef3_q;
  logic         ovf2_q, ovf3_q, st3_q;
  logic [105:0] pn_q;
  logic [63:0]  res_q;

  // partial products of a 53 x 53 significand multiply, one per cycle
  logic [26:0] pa, pb;
  logic [53:0] pp_d;
  logic [105:0] pp_sh;

  assign pa   = cnt_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
  assign pb   = cnt_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
  assign pp_d = pa * pb;

  always_comb begin
    unique case (ppsh_q)
      2'd0:    pp_sh = {52'b0, pp_q};
      2'd1:    pp_sh = {25'b0, pp_q, 27'b0};
      default: pp_sh = {pp_q[51:0], 54'b0};
    endcase
  end

  // leading one, exponent and alignment shift
  logic [6:0]  lead;
  logic [13:0] ee, e_res, sh_d;
  logic        normal, ovf;

  always_comb begin
    lead = '0;
    for (int k = 0; k < 106; k++) begin
      if (acc_q[k]) begin
        lead = 7'(k);
      end
    end
    ee     = 14'(ea_q) + 14'(eb_q);
    e_res  = 14'(lead) + ee - 14'd1127;
    normal = !e_res[13] && (e_res != 14'd0);
    ovf    = !e_res[13] && (e_res >= 14'd2047);
    sh_d   = normal ? (14'd105 - 14'(lead)) : (ee - 14'd1023);
  end

  // alignment
  logic [13:0]  neg_sh;
  logic [6:0]   rs;
  logic [233:0] wide;
  logic [105:0] pn_d;
  logic         st_d;

  always_comb begin
    neg_sh = 14'd0 - sh2_q;
    rs     = (neg_sh > 14'd127) ? 7'd127 : neg_sh[6:0];
    wide   = {acc_q, 128'b0} >> rs;
    if (!sh2_q[13]) begin
      pn_d = acc_q << sh2_q[6:0];
      st_d = 1'b0;
    end else begin
      pn_d = wide[233:128];
      st_d = |wide[127:0];
    end
  end

  // round to nearest even; carry runs into the exponent field
  logic        g, st, inc;
  logic [62:0] mag;

  always_comb begin
    g   = pn_q[52];
    st  = st3_q || (|pn_q[51:0]);
    inc = g && (st || pn_q[53]);
    mag = {ef3_q, 52'b0} + {10'b0, pn_q[105:53]} + 63'(inc);
    if (ovf3_q) begin
      mag = {11'h7FF, 52'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mact_q <= 1'b0;
      ppv_q  <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      ppv_q  <= mact_q;
      v1_q   <= ppv_q && ppl_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      if (start_i) begin
        mact_q <= !is_spec;
        cnt_q  <= '0;
        done_q <= is_spec;
      end else if (mact_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          mact_q <= 1'b0;
        end
      end
      if (v3_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= {|ea, op_i.a[51:0]};
      mb_q   <= {|eb, op_i.b[51:0]};
      ea_q   <= (ea == 11'd0) ? 11'd1 : ea;
      eb_q   <= (eb == 11'd0) ? 11'd1 : eb;
      sign_q <= sa ^ sb;
      acc_q  <= '0;
      res_q  <= spec_res;
    end else if (ppv_q) begin
      acc_q <= acc_q + pp_sh;
    end
    pp_q   <= pp_d;
    ppsh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
    ppl_q  <= (cnt_q == 2'd3);
    if (v1_q) begin
      sh2_q  <= sh_d;
      ef2_q  <= normal ? 11'(e_res - 14'd1) : 11'd0;
      ovf2_q <= ovf;
    end
    if (v2_q) begin
      pn_q   <= pn_d;
      st3_q  <= st_d;
      ef3_q  <= ef2_q;
      ovf3_q <= ovf2_q;
    end
    if (v3_q) begin
      res_q <= {sign_q, mag};
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ rtl/tmv_fadd.sv @@
`default_nettype none

module tmv_fadd import tmv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire fp_op_t      op_i,
  output logic             done_o,
  output logic [63:0]      result_o
);

  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, is_spec, swap;
  logic [10:0] ea, eb;
  logic [63:0] spec_res, x, y;

  assign sa    = op_i.a[63];
  assign sb    = op_i.b[63];
  assign ea    = op_i.a[62:52];
  assign eb    = op_i.b[62:52];
  assign a_nan = (&ea) && (|op_i.a[51:0]);
  assign b_nan = (&eb) && (|op_i.b[51:0]);
  assign a_inf = (&ea) && !(|op_i.a[51:0]);
  assign b_inf = (&eb) && !(|op_i.b[51:0]);
  assign swap  = op_i.b[62:0] > op_i.a[62:0];
  assign x     = swap ? op_i.b : op_i.a;
  assign y     = swap ? op_i.a : op_i.b;

  always_comb begin
    is_spec  = 1'b1;
    spec_res = '0;
    priority if (a_nan) begin
      spec_res = op_i.a | QNAN_BIT;
    end else if (b_nan) begin
      spec_res = op_i.b | QNAN_BIT;
    end else if (a_inf && b_inf && (sa != sb)) begin
      spec_res = DEFAULT_NAN;
    end else if (a_inf) begin
      spec_res = op_i.a;
    end else if (b_inf) begin
      spec_res = op_i.b;
    end else begin
      is_spec = 1'b0;
    end
  end

  logic [52:0] mx_q, my_q;
  logic [10:0] ex_q, d_q;
  logic        sub_q, sign_q, zs_q;
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, done_q;
  logic [55:0] yal_q, nsh_q, n_q;
  logic [56:0] sum_q;
  logic [5:0]  sl_q;
  logic [11:0] e_q, e2_q;
  logic        zero_q, zero2_q;
  logic [63:0] res_q;

  // align the smaller operand, keep shifted-out bits as sticky
  logic [5:0]   dc;
  logic [119:0] wide;
  logic [55:0]  yal_d;

  always_comb begin
    dc    = (d_q > 11'd63) ? 6'd63 : d_q[5:0];
    wide  = {my_q, 3'b0, 64'b0} >> dc;
    yal_d = {wide[119:65], wide[64] | (|wide[63:0])};
  end

  logic [56:0] sum_d;
  assign sum_d = sub_q ? ({1'b0, mx_q, 3'b0} - {1'b0, yal_q})
                       : ({1'b0, mx_q, 3'b0} + {1'b0, yal_q});

  // leading-zero count, clamped so that the result may stay subnormal
  logic [5:0]  lead, lz, sl_d;
  logic [55:0] nsh_d;
  logic [11:0] e_d;

  always_comb begin
    lead = '0;
    for (int k = 0; k < 56; k++) begin
      if (sum_q[k]) begin
        lead = 6'(k);
      end
    end
    lz = 6'd55 - lead;
    if (sum_q[56]) begin
      nsh_d = {sum_q[56:2], sum_q[1] | sum_q[0]};
      e_d   = {1'b0, ex_q} + 12'd1;
      sl_d  = '0;
    end else begin
      nsh_d = sum_q[55:0];
      e_d   = {1'b0, ex_q};
      sl_d  = ({5'b0, lz} < (ex_q - 11'd1)) ? lz : 6'(ex_q - 11'd1);
    end
  end

  logic        inc;
  logic [62:0] mag;

  always_comb begin
    inc = n_q[2] && (n_q[1] || n_q[0] || n_q[3]);
    mag = {11'(e2_q - 12'd1), 52'b0} + {10'b0, n_q[55:3]} + 63'(inc);
    if (e2_q >= 12'd2047) begin
      mag = {11'h7FF, 52'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !is_spec;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= (start_i && is_spec) || v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q   <= {|x[62:52], x[51:0]};
      my_q   <= {|y[62:52], y[51:0]};
      ex_q   <= (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
      d_q    <= ((x[62:52] == 11'd0) ? 11'd1 : x[62:52])
              - ((y[62:52] == 11'd0) ? 11'd1 : y[62:52]);
      sub_q  <= sa ^ sb;
      sign_q <= x[63];
      zs_q   <= sa && sb;
      res_q  <= spec_res;
    end
    if (v1_q) begin
      yal_q <= yal_d;
    end
    if (v2_q) begin
      sum_q <= sum_d;
    end
    if (v3_q) begin
      nsh_q  <= nsh_d;
      e_q    <= e_d;
      sl_q   <= sl_d;
      zero_q <= (sum_q == 57'd0);
    end
    if (v4_q) begin
      n_q     <= nsh_q << sl_q;
      e2_q    <= e_q - 12'(sl_q);
      zero2_q <= zero_q;
    end
    if (v5_q) begin
      res_q <= zero2_q ? {zs_q, 63'b0} : {sign_q, mag};
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ rtl/triangular_matrix_vector_multiply.sv @@
// Entry writes (matrix or vector) give no result. A run of order n does each
// multiply-add with the iterative double multiplier (four 27x27 partial
// products) and the five-stage adder; a row's first term skips the adder and
// each row ends with a write-back (unit diagonal skips the diagonal multiply),
// then the results are emitted one by one; requests stall until done.
// Reset (async, active low) clears control and sets config to defaults; memories are not cleared.
`default_nettype none
`include "triangular_matrix_vector_multiply_macros.svh"

module triangular_matrix_vector_multiply import tmv_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [4:0] row_index, [9:5] column_index, [73:10] entry_value, rest zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [REQ_W-1:0]     s_axis_tuser,
  // result channel
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [4:0] element_index, [68:5] element_value, rest zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic                      m_axis_tlast,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ORD_W-1:0]     cfg_data_i
);

  localparam int unsigned IW     = $clog2(MAX_ORDER);
  localparam int unsigned NW     = $clog2(MAX_ORDER + 1);
  localparam int unsigned DEPTHA = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW     = $clog2(DEPTHA);
  localparam logic [AW-1:0] MO_A = AW'(MAX_ORDER);

  // configuration registers
  logic             lower_q, trans_q, unit_q;
  logic [ORD_W-1:0] order_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 1'b1;
      trans_q <= 1'b0;
      unit_q  <= 1'b0;
      order_q <= ORD_W'(32);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOWER:     lower_q <= cfg_data_i[0];
        CFG_TRANSPOSE: trans_q <= cfg_data_i[0];
        CFG_UNIT:      unit_q  <= cfg_data_i[0];
        CFG_ORDER:     order_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // sequencer state
  tmv_state_e    state_q, state_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [NW-1:0] n_q, n_d;
  logic [63:0]   acc_q, acc_d, term_q, term_d;
  logic          started_q, started_d;

  // output register
  logic             out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;

  // Effective triangle of op(A): the transpose flips lower and upper.
  logic          eff_lower;
  logic [NW-1:0] n_cfg;
  logic [IW-1:0] nm1, i0, hi_i, i_nx;
  logic          last_row, diag, out_free, accept;

  assign eff_lower = lower_q ^ trans_q;
  // Saturate the configured order at the matrix size.
  assign n_cfg     = ({1'b0, order_q} > 7'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(order_q);
  assign nm1       = IW'(n_q - NW'(1));
  assign i0        = eff_lower ? IW'(n_cfg - NW'(1)) : '0;
  assign hi_i      = eff_lower ? i_q : nm1;
  assign i_nx      = eff_lower ? (i_q - IW'(1)) : (i_q + IW'(1));
  assign last_row  = eff_lower ? (i_q == '0) : (i_q == nm1);
  assign diag      = unit_q && (j_q == i_q);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // request fields
  logic [IDX_W-1:0] row_f, col_f;
  logic [VAL_W-1:0] val_f;
  logic             row_ok, col_ok;

  assign row_f  = s_axis_tdata[4:0];
  assign col_f  = s_axis_tdata[9:5];
  assign val_f  = s_axis_tdata[73:10];
  assign row_ok = {2'b0, row_f} < 7'(MAX_ORDER);
  assign col_ok = {2'b0, col_f} < 7'(MAX_ORDER);

  // memories
  logic          mat_we, vec_we;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic [IW-1:0] vec_waddr;
  logic [63:0]   vec_wdata, mat_rdata, vec_rdata;
  logic [IW-1:0] mr_row, mr_col;

  // Row-major layout: entry (r, c) at r*MAX_ORDER + c.
  assign mat_waddr = AW'(IW'(row_f)) * MO_A + AW'(IW'(col_f));
  assign mr_row    = trans_q ? j_q : i_q;
  assign mr_col    = trans_q ? i_q : j_q;
  assign mat_raddr = AW'(mr_row) * MO_A + AW'(mr_col);

  tmv_ram #(.WIDTH(VAL_W), .DEPTH(DEPTHA)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (val_f),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  // The vector is read at the column index during the run and at the
  // result index while emitting, both held in j_q.
  tmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ORDER)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .raddr_i (j_q),
    .rdata_o (vec_rdata)
  );

  // arithmetic units
  fp_op_t      mul_op, add_op;
  logic        mul_start, mul_done, add_start, add_done;
  logic [63:0] mul_res, add_res;

  assign mul_op = '{a: mat_rdata, b: vec_rdata};
  assign add_op = '{a: acc_q, b: term_q};

  tmv_fmul u_fmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .op_i     (mul_op),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  tmv_fadd u_fadd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (add_start),
    .op_i     (add_op),
    .done_o   (add_done),
    .result_o (add_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == REQ_RUN) && (n_cfg != '0)) begin
          state_d = ST_RD;
        end
      end
      ST_RD:   state_d = ST_MS;
      ST_MS:   state_d = diag ? ST_AS : ST_MW;
      ST_MW:   state_d = mul_done ? ST_AS : ST_MW;
      ST_AS:   state_d = started_q ? ST_AW : ST_NX;
      ST_AW:   state_d = add_done ? ST_NX : ST_AW;
      ST_NX:   state_d = (j_q == hi_i) ? ST_WB : ST_RD;
      ST_WB:   state_d = last_row ? ST_ER : ST_RD;
      ST_ER:   state_d = ST_EO;
      ST_EO: begin
        if (out_free) begin
          state_d = (j_q == nm1) ? ST_IDLE : ST_ER;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    acc_d       = acc_q;
    term_d      = term_q;
    started_d   = started_q;
    mat_we      = 1'b0;
    vec_we      = 1'b0;
    vec_waddr   = IW'(row_f);
    vec_wdata   = val_f;
    mul_start   = 1'b0;
    add_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            REQ_MAT_WR: mat_we = row_ok && col_ok;
            REQ_VEC_WR: vec_we = row_ok;
            REQ_RUN: begin
              // start at the row whose write-back cannot disturb later rows
              n_d       = n_cfg;
              i_d       = i0;
              j_d       = eff_lower ? '0 : i0;
              started_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_MS: begin
        if (diag) begin
          term_d = vec_rdata;
        end else begin
          mul_start = 1'b1;
        end
      end
      ST_MW: begin
        if (mul_done) begin
          term_d = mul_res;
        end
      end
      ST_AS: begin
        if (started_q) begin
          add_start = 1'b1;
        end else begin
          acc_d     = term_q;
          started_d = 1'b1;
        end
      end
      ST_AW: begin
        if (add_done) begin
          acc_d = add_res;
        end
      end
      ST_NX: begin
        if (j_q != hi_i) begin
          j_d = j_q + IW'(1);
        end
      end
      ST_WB: begin
        // write the finished row back in place
        vec_we    = 1'b1;
        vec_waddr = i_q;
        vec_wdata = acc_q;
        started_d = 1'b0;
        if (last_row) begin
          j_d = '0;
        end else begin
          i_d = i_nx;
          j_d = eff_lower ? '0 : i_nx;
        end
      end
      ST_EO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = IDX_W'(j_q);
          out_val_d   = vec_rdata;
          out_last_d  = (j_q == nm1);
          j_d         = j_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    term_q     <= term_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  `TMV_ASSERT_IMP(a_mul_done_wait, mul_done, state_q == ST_MW, "product outside multiply wait")
  `TMV_ASSERT_IMP(a_add_done_wait, add_done, state_q == ST_AW, "sum outside add wait")
  `TMV_ASSERT_IMP(a_wb_started, state_q == ST_WB, started_q, "row written back without a term")
  `TMV_ASSERT_NXT(a_emit_load, (state_q == ST_EO) && out_free, m_axis_tvalid, "result not shown")

endmodule

`default_nettype wire
